// ===== sv/sis_pkg.sv =====
// Shared types, constants and state encodings of the interval schedule selector.
package sis_pkg;

   // Default depth of the activity store.
   localparam int MAX_ACTIVITIES_DEF = 64;

   // Most results that one set can produce.
   localparam int RESULT_LIMIT = 64;
   localparam int PICK_W       = $clog2(RESULT_LIMIT + 1);

   // Depth of the queue between the sorter and the selector (a power of two).
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // One stored activity.
   typedef struct packed {
      logic [15:0] start;
      logic [15:0] finish;
      logic [15:0] id;
   } act_type;

   // Input transaction payload.
   typedef struct packed {
      logic [15:0] start_time;
      logic [15:0] finish_time;
      logic [15:0] act_id;
      logic        set_end;
   } req_type;

   // Result transaction payload.
   typedef struct packed {
      logic [15:0] chosen_id;
      logic        final_pick;
      logic        overflowed;
   } rsp_type;

   // Sorted activity handed from the sorter to the selector.
   typedef struct packed {
      act_type act;
      logic    first;
      logic    last;
      logic    ovf;
   } entry_type;

   typedef enum logic {
      FRONT_LOAD,
      FRONT_DRAIN
   } front_state_type;

   typedef enum logic {
      BACK_SCAN,
      BACK_FLUSH
   } back_state_type;

endpackage

// ===== sv/interval_schedule_selector_unit.sv =====
// Top level of the interval schedule selector: sorter, queue and selector.
//
// Activities enter as input transactions on push/full, one per cycle while the
// block loads a set. Each is inserted at once into a sorted chain of cells, ordered
// by finish time or, with sort_by_start set, by start time; equal keys keep their
// arrival order. The transaction with set_end closes the set. Activities beyond
// MAX_ACTIVITIES are dropped and every result of that set carries overflowed.
// After the closing transaction, full stays high while the chain drains one cell per
// cycle, unless the queue is full, into a four-entry queue. The selector takes one
// sorted activity per cycle unless stalled by the output register or a set's end,
// keeps the first of a set and those that start no earlier than the finish of the
// last one kept, and holds each kept one back until the next is kept or the set
// ends; the last one is marked by final_pick. At most 64 results
// are produced per set. Results wait in an output register read through
// empty/pop; a stalled receiver backs up the selector, then the queue, then the
// drain. Synchronous reset empties the chain, the queue and the output register
// and clears sort_by_start; the single CSR is written whenever csr_wr_en is high.
module interval_schedule_selector_unit #(
   parameter int MAX_ACTIVITIES = sis_pkg::MAX_ACTIVITIES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  sis_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output sis_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data
);
   import sis_pkg::*;

   logic      sort_by_start_ff, sort_by_start_in;
   logic      q_push;
   logic      q_full;
   logic      q_pop;
   logic      q_empty;
   entry_type q_in_data;
   entry_type q_out_data;

   // Mode register.
   assign sort_by_start_in = csr_wr_en ? csr_wr_data : sort_by_start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sort_by_start_ff <= 1'b0;
      end else begin
         sort_by_start_ff <= sort_by_start_in;
      end
   end

   sis_front #(
      .MAX_ACT(MAX_ACTIVITIES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .sort_by_start(sort_by_start_ff),
      .push         (push),
      .full         (full),
      .req_data     (req_data),
      .q_push       (q_push),
      .q_data       (q_in_data),
      .q_full       (q_full)
   );

   sis_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_push  (q_push),
      .in_data  (q_in_data),
      .in_full  (q_full),
      .out_pop  (q_pop),
      .out_data (q_out_data),
      .out_empty(q_empty)
   );

   sis_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_data   (q_out_data),
      .q_pop    (q_pop),
      .rsp_empty(empty),
      .rsp_pop  (pop),
      .rsp_data (rsp_data)
   );

`ifndef SYNTHESIS
   // A closing transaction stops the input for at least the drain of the set.
   a_close_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (push && !full && req_data.set_end) |=> full)
      else $error("input accepted right after a closing transaction");

   // The sorter only drains while it blocks the input.
   a_drain_only_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> full)
      else $error("queue written while the input is open");

   // The selector never pops an empty queue.
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("selector popped an empty queue");
`endif

endmodule

// ===== sv/sis_front.sv =====
// Front end: accepts activities, keeps them sorted in a cell chain and drains the set in order.
module sis_front #(
   parameter int MAX_ACT = sis_pkg::MAX_ACTIVITIES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               sort_by_start,
   input  logic               push,
   output logic               full,
   input  sis_pkg::req_type   req_data,
   output logic               q_push,
   output sis_pkg::entry_type q_data,
   input  logic               q_full
);
   import sis_pkg::*;

   localparam int CNT_W = $clog2(MAX_ACT + 1);

   act_type          cell_ff [MAX_ACT];
   act_type          cell_in [MAX_ACT];
   logic             gt      [MAX_ACT];
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic             first_ff, first_in;
   front_state_type  state_ff, state_in;
   logic             accept;
   logic             insert;
   logic [15:0]      new_key;
   act_type          act_new;

   // The incoming activity and its sort key.
   assign act_new = '{start: req_data.start_time, finish: req_data.finish_time,
                      id: req_data.act_id};
   assign new_key = sort_by_start ? req_data.start_time : req_data.finish_time;

   // Each cell decides on its own whether it moves up for a new activity or moves
   // down while the set drains. Equal keys stay in front, which keeps arrival order.
   for (genvar i = 0; i < MAX_ACT; i++) begin : g_cell
      logic [15:0] key;
      assign key   = sort_by_start ? cell_ff[i].start : cell_ff[i].finish;
      assign gt[i] = (CNT_W'(i) >= count_ff) || (key > new_key);

      always_comb begin
         cell_in[i] = cell_ff[i];
         if (insert && gt[i]) begin
            if (i == 0) begin
               cell_in[i] = act_new;
            end else if (gt[(i == 0) ? 0 : i - 1]) begin
               cell_in[i] = cell_ff[(i == 0) ? 0 : i - 1];
            end else begin
               cell_in[i] = act_new;
            end
         end else if (q_push) begin
            if (i < MAX_ACT - 1) begin
               cell_in[i] = cell_ff[(i < MAX_ACT - 1) ? i + 1 : i];
            end
         end
      end
   end

   // Load and drain sequencer.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      first_in = first_ff;
      full     = (state_ff != FRONT_LOAD);
      accept   = push && !full;
      insert   = accept && (count_ff < CNT_W'(MAX_ACT));
      q_push   = 1'b0;
      q_data   = '{act: cell_ff[0], first: first_ff,
                   last: (count_ff == CNT_W'(1)), ovf: ovf_ff};
      unique case (state_ff)
         FRONT_LOAD: begin
            if (accept) begin
               if (insert) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_data.set_end) begin
                  state_in = FRONT_DRAIN;
                  first_in = 1'b1;
               end
            end
         end
         FRONT_DRAIN: begin
            q_push = !q_full;
            if (!q_full) begin
               count_in = count_ff - CNT_W'(1);
               first_in = 1'b0;
               if (count_ff == CNT_W'(1)) begin
                  state_in = FRONT_LOAD;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: begin
            state_in = FRONT_LOAD;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         first_ff <= first_in;
      end
   end

   // Cell contents carry no reset.
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_ACT; i++) begin
         cell_ff[i] <= cell_in[i];
      end
   end

endmodule

// ===== sv/sis_queue.sv =====
// Short queue of sorted activities between the sorter and the selector.
module sis_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_push,
   input  sis_pkg::entry_type in_data,
   output logic               in_full,
   input  logic               out_pop,
   output sis_pkg::entry_type out_data,
   output logic               out_empty
);
   import sis_pkg::*;

   entry_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;
   logic              do_push;
   logic              do_pop;

   // Occupancy and pointer updates.
   always_comb begin
      in_full   = (cnt_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
      out_empty = (cnt_ff == '0);
      do_push   = in_push && !in_full;
      do_pop    = out_pop && !out_empty;
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);
      out_data  = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Storage is written in place and needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ===== sv/sis_back.sv =====
// Back end: greedy selection over the sorted stream and the result register.
module sis_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  sis_pkg::entry_type q_data,
   output logic               q_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output sis_pkg::rsp_type   rsp_data
);
   import sis_pkg::*;

   back_state_type    state_ff, state_in;
   logic [15:0]       last_fin_ff, last_fin_in;
   logic [PICK_W-1:0] pick_cnt_ff, pick_cnt_in;
   logic [15:0]       pend_id_ff, pend_id_in;
   logic              pend_ovf_ff, pend_ovf_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              out_taken;
   logic              out_free;
   logic              has_pend;
   logic              sel;

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The most recent pick is held back until it is known whether it ends the set.
   always_comb begin
      state_in     = state_ff;
      last_fin_in  = last_fin_ff;
      pick_cnt_in  = pick_cnt_ff;
      pend_id_in   = pend_id_ff;
      pend_ovf_in  = pend_ovf_ff;
      out_taken    = rsp_pop && rsp_valid_ff;
      out_free     = !rsp_valid_ff || out_taken;
      rsp_valid_in = rsp_valid_ff && !out_taken;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      has_pend     = (pick_cnt_ff != '0);
      sel          = (pick_cnt_ff != PICK_W'(RESULT_LIMIT)) &&
                     (q_data.first || (q_data.act.start >= last_fin_ff));
      unique case (state_ff)
         BACK_SCAN: begin
            if (!q_empty && !(sel && has_pend && !out_free)) begin
               q_pop = 1'b1;
               if (sel) begin
                  if (has_pend) begin
                     rsp_valid_in = 1'b1;
                     rsp_in = '{chosen_id: pend_id_ff, final_pick: 1'b0,
                                overflowed: pend_ovf_ff};
                  end
                  pend_id_in  = q_data.act.id;
                  pend_ovf_in = q_data.ovf;
                  last_fin_in = q_data.act.finish;
                  pick_cnt_in = pick_cnt_ff + PICK_W'(1);
               end
               if (q_data.last) begin
                  state_in = BACK_FLUSH;
               end
            end
         end
         BACK_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{chosen_id: pend_id_ff, final_pick: 1'b1,
                          overflowed: pend_ovf_ff};
               pick_cnt_in = '0;
               state_in    = BACK_SCAN;
            end
         end
         default: begin
            state_in = BACK_SCAN;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_SCAN;
         last_fin_ff  <= '0;
         pick_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_fin_ff  <= last_fin_in;
         pick_cnt_ff  <= pick_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pend_id_ff  <= pend_id_in;
      pend_ovf_ff <= pend_ovf_in;
      rsp_ff      <= rsp_in;
   end

endmodule

// ===== bench/interval_schedule_selector_checker.sv =====
// Scoreboard for the interval schedule selector: predicts the chosen activities and compares them.
`timescale 1ns / 1ps

module interval_schedule_selector_checker #(
   parameter int MAX_ACTIVITIES = sis_pkg::MAX_ACTIVITIES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic             full,
   input  sis_pkg::req_type req_data,
   input  logic             empty,
   input  logic             pop,
   input  sis_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data,
   output int               mismatch_count,
   output int               pending_count
);
   import sis_pkg::*;

   // Shadow of the block: the activities of the open set, its overflow flag and the ordering mode.
   act_type set_store [MAX_ACTIVITIES];
   int      stored_count;
   logic    set_overflow;
   logic    by_start;

   // Chosen activities that the block still owes, oldest first.
   rsp_type expected_picks [$];

   // Prints one line per mismatch and counts it.
   task automatic report_mismatch(input string msg);
      $display("%0t ns schedule check: %s", $time, msg);
      mismatch_count++;
   endtask

   // Sort key of an activity under the current ordering mode.
   function automatic logic [15:0] order_key(input act_type a);
      return by_start ? a.start : a.finish;
   endfunction

   // Stable insertion sort of the closed set by the current key, then the greedy selection in that order.
   task automatic schedule_set();
      act_type     order [MAX_ACTIVITIES];
      rsp_type     picked [RESULT_LIMIT];
      act_type     moving;
      logic [15:0] kept_finish;
      int          i;
      int          j;
      int          picks;
      for (i = 0; i < stored_count; i++) order[i] = set_store[i];
      for (i = 1; i < stored_count; i++) begin
         moving = order[i];
         j = i;
         while (j > 0 && order_key(order[j - 1]) > order_key(moving)) begin
            order[j] = order[j - 1];
            j--;
         end
         order[j] = moving;
      end
      picks = 0;
      kept_finish = '0;
      for (i = 0; i < stored_count && picks < RESULT_LIMIT; i++) begin
         if (i == 0 || order[i].start >= kept_finish) begin
            kept_finish = order[i].finish;
            picked[picks].chosen_id = order[i].id;
            picked[picks].final_pick = 1'b0;
            picked[picks].overflowed = set_overflow;
            picks++;
         end
      end
      // The last pick of the set carries the end marker.
      if (picks > 0) picked[picks - 1].final_pick = 1'b1;
      for (i = 0; i < picks; i++) expected_picks.insert(expected_picks.size(), picked[i]);
      stored_count = 0;
      set_overflow = 1'b0;
   endtask

   // Stores one accepted activity, dropping it when the store is full, and schedules the set on its closing one.
   task automatic take_activity(input req_type item);
      if (stored_count < MAX_ACTIVITIES) begin
         set_store[stored_count].start = item.start_time;
         set_store[stored_count].finish = item.finish_time;
         set_store[stored_count].id = item.act_id;
         stored_count++;
      end else begin
         set_overflow = 1'b1;
      end
      if (item.set_end) schedule_set();
   endtask

   // Compares one accepted result with the oldest expected pick, field by field.
   task automatic check_pick(input rsp_type seen);
      rsp_type want;
      if (expected_picks.size() == 0) begin
         report_mismatch($sformatf("result with id %h while none is expected", seen.chosen_id));
         return;
      end
      want = expected_picks.pop_front();
      if (seen.chosen_id !== want.chosen_id)
         report_mismatch($sformatf("chosen_id %h, expected %h", seen.chosen_id, want.chosen_id));
      if (seen.final_pick !== want.final_pick)
         report_mismatch($sformatf("final_pick %b on id %h, expected %b",
                                   seen.final_pick, want.chosen_id, want.final_pick));
      if (seen.overflowed !== want.overflowed)
         report_mismatch($sformatf("overflowed %b on id %h, expected %b",
                                   seen.overflowed, want.chosen_id, want.overflowed));
   endtask

   // Watch both channels and the register port at every rising edge.
   always @(posedge clock) begin
      if (reset) begin
         stored_count = 0;
         set_overflow = 1'b0;
         by_start = 1'b0;
         expected_picks.delete();
      end else begin
         if (csr_wr_en) by_start = csr_wr_data;
         if (pop && !empty) check_pick(rsp_data);
         if (push && !full) take_activity(req_data);
      end
      pending_count = expected_picks.size();
   end

endmodule

// ===== bench/interval_schedule_selector_unit_tb.sv =====
// Testbench top for the interval schedule selector: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module interval_schedule_selector_unit_tb;
   import sis_pkg::*;

   localparam int MAX_ACTIVITIES = MAX_ACTIVITIES_DEF;
   localparam int SETTLE_CYCLES  = 16;
   localparam int TAIL_CYCLES    = 2 * MAX_ACTIVITIES + 20;
   localparam int HOLD_CYCLES    = 300;
   localparam int STALL_LIMIT    = 3000;
   localparam int IDLE_PERCENT   = 36;

   logic    clock;
   logic    reset       = 1'b1;
   logic    push        = 1'b0;
   logic    full;
   req_type req_data    = '0;
   logic    empty;
   logic    pop         = 1'b0;
   rsp_type rsp_data;
   logic    csr_wr_en   = 1'b0;
   logic    csr_wr_data = 1'b0;

   int mismatch_count;
   int pending_count;

   // Shared flow-control knobs: a stretch without idling and a request for a long receiver hold.
   bit calm         = 1'b0;
   bit hold_request = 1'b0;
   int idle_cycles  = 0;

   interval_schedule_selector_unit #(
      .MAX_ACTIVITIES(MAX_ACTIVITIES)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   interval_schedule_selector_checker #(
      .MAX_ACTIVITIES(MAX_ACTIVITIES)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_data      (req_data),
      .empty         (empty),
      .pop           (pop),
      .rsp_data      (rsp_data),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .mismatch_count(mismatch_count),
      .pending_count (pending_count)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Builds one activity transaction.
   function automatic req_type make_activity(input logic [15:0] start, input logic [15:0] finish,
                                             input logic [15:0] id, input logic last);
      req_type item;
      item.start_time = start;
      item.finish_time = finish;
      item.act_id = id;
      item.set_end = last;
      return item;
   endfunction

   // Random activity: mostly short intervals on a narrow time line, some wide and some extreme.
   function automatic req_type random_activity(input logic last);
      int          style;
      logic [15:0] start;
      logic [15:0] finish;
      style = $urandom_range(0, 99);
      if (style < 70) begin
         start = 16'($urandom_range(0, 200));
         finish = start + 16'($urandom_range(0, 40));
      end else if (style < 88) begin
         start = 16'($urandom);
         finish = 16'($urandom);
      end else begin
         start = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         finish = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end
      return make_activity(start, finish, 16'($urandom), last);
   endfunction

   // Offers one activity, with random idle cycles first, and returns once it is accepted.
   task automatic send_activity(input req_type item);
      while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (full);
   endtask

   // Sends a set of random activities; the last one closes the set.
   task automatic send_random_set(input int size);
      int k;
      for (k = 0; k < size; k++) send_activity(random_activity(k == size - 1));
   endtask

   // Lets the block drain: every expected result delivered, then a short quiet period.
   task automatic settle();
      push <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the ordering mode register.
   task automatic set_mode(input logic by_start);
      csr_wr_en <= 1'b1;
      csr_wr_data <= by_start;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Overlapping activities with equal finish times and a zero-length one.
   task automatic send_mixed_set();
      send_activity(make_activity(16'd5, 16'd10, 16'd10, 1'b0));
      send_activity(make_activity(16'd1, 16'd10, 16'd11, 1'b0));
      send_activity(make_activity(16'd10, 16'd20, 16'd12, 1'b0));
      send_activity(make_activity(16'd0, 16'hFFFF, 16'd13, 1'b0));
      send_activity(make_activity(16'd20, 16'd20, 16'd14, 1'b0));
      send_activity(make_activity(16'd12, 16'd30, 16'd15, 1'b1));
   endtask

   // Receiver: random pops, with one long hold when requested.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            pop <= 1'b0;
            hold_request = 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         pop <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // Watchdog: ends the run when no transaction is accepted for too long.
   initial begin
      forever begin
         @(posedge clock);
         if (reset || (push && !full) || (pop && !empty)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("interval_schedule_selector_unit_tb: errors");
            $finish;
         end
      end
   end

   // Main stimulus sequence.
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed sets, ordered by finish time.
      set_mode(1'b0);
      send_activity(make_activity(16'hFFFF, 16'h0000, 16'hFFFF, 1'b1));
      send_activity(make_activity(16'h0000, 16'h0000, 16'h0000, 1'b0));
      send_activity(make_activity(16'h0000, 16'h0000, 16'h0001, 1'b0));
      send_activity(make_activity(16'h0000, 16'h0000, 16'h0002, 1'b1));
      send_mixed_set();
      send_activity(make_activity(16'd100, 16'd50, 16'd20, 1'b0));
      send_activity(make_activity(16'd40, 16'd60, 16'd21, 1'b0));
      send_activity(make_activity(16'hFFFF, 16'hFFFF, 16'd22, 1'b1));
      settle();

      // Directed sets, ordered by start time, including equal start times.
      set_mode(1'b1);
      send_mixed_set();
      send_activity(make_activity(16'd7, 16'd1, 16'd30, 1'b0));
      send_activity(make_activity(16'd7, 16'd9, 16'd31, 1'b0));
      send_activity(make_activity(16'd3, 16'd8, 16'd32, 1'b1));
      settle();

      // The receiver holds off while one random set drains and the next one is offered,
      // so the block backs up into its input.
      hold_request = 1'b1;
      send_random_set(12);
      send_random_set(3);
      settle();

      // With no idling on either side, a set that fills the store and then overflows it,
      // losing its closing activity.
      set_mode(1'b0);
      calm = 1'b1;
      send_random_set(MAX_ACTIVITIES + 3);
      settle();
      calm = 1'b0;

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("interval_schedule_selector_unit_tb: clean");
      end else begin
         $display("interval_schedule_selector_unit_tb: errors");
      end
      $finish;
   end

endmodule
